// ----- sv/chov_pkg.sv -----
// ----------------------------------------------------------------------------
// chov_pkg
// Shared types and constants of the chunk hash overlap counter.
// ----------------------------------------------------------------------------
package chov_pkg;

  localparam int SIZE_W     = 13;
  localparam int VAL_W      = 17;
  localparam int MOD_CNT_W  = 5;
  localparam int OVERLAP_W  = 28;
  localparam int BUCKET_W   = 12;
  localparam int DOC_W_IN   = 3;

  localparam logic [SIZE_W-1:0]    TABLE_SIZE_RST = 13'd4096;
  localparam logic [OVERLAP_W-1:0] OVERLAP_MAX    = 28'hFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_CHAR  = 2'd0,
    MODE_WORD  = 2'd1,
    MODE_CHUNK = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  typedef struct packed {
    mode_t                mode;
    logic [7:0]           char_byte;
    logic [DOC_W_IN-1:0]  doc_id;
    logic [DOC_W_IN-1:0]  other_doc;
  } in_word_t;

  typedef struct packed {
    kind_t                kind;
    logic [BUCKET_W-1:0]  bucket;
    logic [OVERLAP_W-1:0] overlap;
  } out_word_t;

  typedef logic [SIZE_W-1:0] cfg_word_t;

endpackage

// ----- sv/chov_stream_if.sv -----
// ----------------------------------------------------------------------------
// chov_stream_if
// Valid/ready channel that moves one word per handshake.
// ----------------------------------------------------------------------------
interface chov_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/chov_mod_unit.sv -----
// ----------------------------------------------------------------------------
// chov_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module chov_mod_unit
  import chov_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VAL_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [SIZE_W-1:0] result
);

  logic [VAL_W-1:0]     dvd_r;
  logic [SIZE_W-1:0]    dvs_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      diff;
  logic [SIZE_W-1:0]    rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[VAL_W-1]};
    diff  = trial - {1'b0, dvs_r};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = diff[SIZE_W-1:0];
    end else begin
      rem_nxt = trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= MOD_CNT_W'(VAL_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == MOD_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[VAL_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done   = done_r;
  assign result = rem_r;

endmodule

// ----- sv/chov_ovl_acc.sv -----
// ----------------------------------------------------------------------------
// chov_ovl_acc
// Takes the smaller of two counts and adds it to a saturating sum.
// ----------------------------------------------------------------------------
module chov_ovl_acc
  import chov_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  clear,
  input  logic                  add_en,
  input  logic [COUNT_BITS-1:0] cnt_a,
  input  logic [COUNT_BITS-1:0] cnt_b,
  output logic [OVERLAP_W-1:0]  sum
);

  logic [OVERLAP_W-1:0]  sum_r;
  logic [OVERLAP_W-1:0]  sum_nxt;
  logic [COUNT_BITS-1:0] smaller;
  logic [32:0]           total;

  always_comb begin
    smaller = (cnt_a < cnt_b) ? cnt_a : cnt_b;
    total   = 33'(sum_r) + 33'(smaller);
    if (total > 33'(OVERLAP_MAX)) begin
      sum_nxt = OVERLAP_MAX;
    end else begin
      sum_nxt = total[OVERLAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      sum_r <= '0;
    end else if (add_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// ----- sv/chunk_hash_overlap_counter.sv -----
// ----------------------------------------------------------------------------
// chunk_hash_overlap_counter
// Hashes text chunks into per-document bucket counters and answers overlap
// queries between two documents.
// A character runs through the bit-serial remainder unit (17 steps); a chunk
// end does so too, then increments its bucket count. A query scans the
// effective table size, one bucket per cycle. One item is in flight at a time.
// After reset a clearing pass zeroes all DOC_COUNT * 2**clog2(TABLE_ENTRIES)
// entries of the count memory (32768 by default).
// ----------------------------------------------------------------------------
module chunk_hash_overlap_counter
  import chov_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096,
  parameter int DOC_COUNT     = 8,
  parameter int COUNT_BITS    = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  chov_stream_if.sink  in_if,
  chov_stream_if.source out_if,
  chov_stream_if.sink  cfg_if
);

  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int DOC_W     = $clog2(DOC_COUNT);
  localparam int MEM_AW    = DOC_W + IDX_W;
  localparam int MEM_DEPTH = DOC_COUNT * (2 ** IDX_W);
  localparam int TE_CLAMP  = (TABLE_ENTRIES > 8191) ? 8191 : TABLE_ENTRIES;
  localparam logic [SIZE_W-1:0] SIZE_CLAMP = SIZE_W'(TE_CLAMP);
  localparam logic [MEM_AW-1:0] CLR_LAST   = MEM_AW'(MEM_DEPTH - 1);
  localparam logic [8:0]        DOC_LIM    = 9'(DOC_COUNT);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_MOD_GO   = 9'b000000100,
    S_MOD_WAIT = 9'b000001000,
    S_INS_RD   = 9'b000010000,
    S_INS_WR   = 9'b000100000,
    S_Q_RUN    = 9'b001000000,
    S_Q_DRAIN  = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [SIZE_W-1:0]    table_size_r, table_size_nxt;
  logic [SIZE_W-1:0]    rem_r, rem_nxt;
  logic [7:0]           prev_r, prev_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic [MEM_AW-1:0]    clr_r, clr_nxt;
  logic                 q_vld_r, q_vld_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;
  logic [15:0]          prod_r, prod_nxt;
  kind_t                kind_r, kind_nxt;
  logic                 is_chunk_r, is_chunk_nxt;
  logic [DOC_W_IN-1:0]  doc_r, doc_nxt;
  logic [DOC_W_IN-1:0]  other_r, other_nxt;
  logic [SIZE_W-1:0]    bucket_r, bucket_nxt;
  logic [SIZE_W-1:0]    qidx_r, qidx_nxt;

  logic [COUNT_BITS-1:0] cnt_mem [MEM_DEPTH];
  logic [COUNT_BITS-1:0] rd_a_r, rd_b_r;
  logic                  mem_we;
  logic [MEM_AW-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [MEM_AW-1:0]     raddr_a, raddr_b;

  logic [SIZE_W-1:0]    eff_size;
  logic [15:0]          bucket_wide, qidx_wide, idx_a_wide;
  logic [8:0]           doc_wide, other_wide, in_doc_wide, in_other_wide;
  logic                 doc_ok, in_doc_ok, in_other_ok;
  logic                 mod_start, mod_done;
  logic [SIZE_W-1:0]    mod_res;
  logic [VAL_W-1:0]     mod_dividend;
  logic                 acc_clear;
  logic [OVERLAP_W-1:0] acc_sum;

  assign eff_size = (table_size_r == '0) ? SIZE_W'(1) :
                    (table_size_r > SIZE_CLAMP) ? SIZE_CLAMP : table_size_r;

  assign doc_wide      = {6'd0, doc_r};
  assign other_wide    = {6'd0, other_r};
  assign in_doc_wide   = {6'd0, in_if.data.doc_id};
  assign in_other_wide = {6'd0, in_if.data.other_doc};
  assign doc_ok        = doc_wide < DOC_LIM;
  assign in_doc_ok     = in_doc_wide < DOC_LIM;
  assign in_other_ok   = in_other_wide < DOC_LIM;

  assign bucket_wide = {3'd0, bucket_r};
  assign qidx_wide   = {3'd0, qidx_r};
  assign idx_a_wide  = (state_r == S_Q_RUN) ? qidx_wide : bucket_wide;
  assign raddr_a     = {doc_wide[DOC_W-1:0], idx_a_wide[IDX_W-1:0]};
  assign raddr_b     = {other_wide[DOC_W-1:0], qidx_wide[IDX_W-1:0]};

  assign mod_dividend = VAL_W'(rem_r) + VAL_W'(prod_r);

  chov_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (eff_size),
    .done     (mod_done),
    .result   (mod_res)
  );

  chov_ovl_acc #(
    .COUNT_BITS (COUNT_BITS)
  ) u_acc (
    .clk    (clk),
    .clear  (acc_clear),
    .add_en (q_vld_r),
    .cnt_a  (rd_a_r),
    .cnt_b  (rd_b_r),
    .sum    (acc_sum)
  );

  always_comb begin
    state_nxt      = state_r;
    table_size_nxt = table_size_r;
    rem_nxt        = rem_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    clr_nxt        = clr_r;
    q_vld_nxt      = (state_r == S_Q_RUN);
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    prod_nxt       = prod_r;
    kind_nxt       = kind_r;
    is_chunk_nxt   = is_chunk_r;
    doc_nxt        = doc_r;
    other_nxt      = other_r;
    bucket_nxt     = bucket_r;
    qidx_nxt       = qidx_r;
    mod_start      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = clr_r;
    mem_wdata      = '0;
    acc_clear      = 1'b0;

    if (cfg_if.valid) begin
      table_size_nxt = cfg_if.data;
    end
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_if.valid) begin
          doc_nxt   = in_if.data.doc_id;
          other_nxt = in_if.data.other_doc;
          unique case (in_if.data.mode)
            MODE_CHAR: begin
              prod_nxt      = have_prev_r ?
                              16'(prev_r) * 16'(in_if.data.char_byte) : 16'd0;
              prev_nxt      = in_if.data.char_byte;
              have_prev_nxt = 1'b1;
              is_chunk_nxt  = 1'b0;
              state_nxt     = S_MOD_GO;
            end
            MODE_WORD: begin
              have_prev_nxt = 1'b0;
            end
            MODE_CHUNK: begin
              prod_nxt      = 16'd0;
              have_prev_nxt = 1'b0;
              is_chunk_nxt  = 1'b1;
              kind_nxt      = KIND_INSERT;
              state_nxt     = S_MOD_GO;
            end
            MODE_QUERY: begin
              kind_nxt  = KIND_QUERY;
              acc_clear = 1'b1;
              qidx_nxt  = '0;
              if ((in_if.data.doc_id != in_if.data.other_doc) &&
                  in_doc_ok && in_other_ok) begin
                state_nxt = S_Q_RUN;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_MOD_GO: begin
        mod_start = 1'b1;
        state_nxt = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (mod_done) begin
          if (is_chunk_r) begin
            bucket_nxt = mod_res;
            rem_nxt    = '0;
            state_nxt  = S_INS_RD;
          end else begin
            rem_nxt   = mod_res;
            state_nxt = S_IDLE;
          end
        end
      end
      S_INS_RD: begin
        state_nxt = doc_ok ? S_INS_WR : S_EMIT;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = raddr_a;
        mem_wdata = (&rd_a_r) ? rd_a_r : rd_a_r + 1'b1;
        state_nxt = S_EMIT;
      end
      S_Q_RUN: begin
        qidx_nxt = qidx_r + 1'b1;
        if (qidx_r == eff_size - 1'b1) begin
          state_nxt = S_Q_DRAIN;
        end
      end
      S_Q_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt        = 1'b1;
          out_word_nxt.kind    = kind_r;
          out_word_nxt.bucket  = (kind_r == KIND_QUERY) ? '0 : bucket_r[BUCKET_W-1:0];
          out_word_nxt.overlap = (kind_r == KIND_QUERY) ? acc_sum : '0;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      table_size_r <= TABLE_SIZE_RST;
      rem_r        <= '0;
      prev_r       <= '0;
      have_prev_r  <= 1'b0;
      clr_r        <= '0;
      q_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      table_size_r <= table_size_nxt;
      rem_r        <= rem_nxt;
      prev_r       <= prev_nxt;
      have_prev_r  <= have_prev_nxt;
      clr_r        <= clr_nxt;
      q_vld_r      <= q_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    prod_r     <= prod_nxt;
    kind_r     <= kind_nxt;
    is_chunk_r <= is_chunk_nxt;
    doc_r      <= doc_nxt;
    other_r    <= other_nxt;
    bucket_r   <= bucket_nxt;
    qidx_r     <= qidx_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= cnt_mem[raddr_a];
    rd_b_r <= cnt_mem[raddr_b];
  end

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_word_r;

endmodule
